// ===== rtl/tfsk_pkg.sv =====
`default_nettype none

package tfsk_pkg;

    // Command codes
    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_BYTE     = 3'd1;
    localparam logic [2:0] CMD_LEADER   = 3'd2;
    localparam logic [2:0] CMD_CHECKSUM = 3'd3;
    localparam logic [2:0] CMD_CLEAR    = 3'd4;

    localparam int unsigned BIT_TICKS = 147;
    localparam logic [7:0]  TICK_LAST = 8'(BIT_TICKS - 1);
    localparam logic [3:0]  FRAME_LEN = 4'd10;

    localparam logic signed [15:0] LEVEL_HIGH16 = 16'sh4000;
    localparam logic signed [15:0] LEVEL_LOW16  = 16'shC000;
    localparam logic signed [15:0] LEVEL_HIGH8  = 16'sh00C0;
    localparam logic signed [15:0] LEVEL_LOW8   = 16'sh0040;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] data_byte;
    } req_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               sample_valid;
        logic               accepted;
        logic               busy_res;
        logic [7:0]         checksum;
    } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/tfsk_level.sv =====
`default_nettype none

module tfsk_level
    import tfsk_pkg::*;
(
    input  wire logic [7:0]         tick_index,
    input  wire logic               bit_value,
    input  wire logic               eight_bit_mode,
    output logic signed [15:0]      level
);

    localparam logic [8:0]  TICKS9 = 9'(BIT_TICKS);
    localparam logic [10:0] EDGE1  = 11'(BIT_TICKS * 1);
    localparam logic [10:0] EDGE2  = 11'(BIT_TICKS * 2);
    localparam logic [10:0] EDGE3  = 11'(BIT_TICKS * 3);
    localparam logic [10:0] EDGE4  = 11'(BIT_TICKS * 4);
    localparam logic [10:0] EDGE5  = 11'(BIT_TICKS * 5);
    localparam logic [10:0] EDGE6  = 11'(BIT_TICKS * 6);
    localparam logic [10:0] EDGE7  = 11'(BIT_TICKS * 7);

    logic [8:0]  twice;
    logic [8:0]  twice_wrap;
    logic [7:0]  phase;
    logic [10:0] phase8;
    logic        high;

    always_comb
    begin
        twice      = {tick_index, 1'b0};
        twice_wrap = (twice >= TICKS9) ? twice - TICKS9 : twice;
        // a one bit runs at twice the tone frequency
        phase      = bit_value ? twice_wrap[7:0] : tick_index;
        phase8     = {phase, 3'b000};
        // odd eighth of the bit period gives the high half-cycle
        high = ((phase8 >= EDGE1) && (phase8 < EDGE2)) ||
               ((phase8 >= EDGE3) && (phase8 < EDGE4)) ||
               ((phase8 >= EDGE5) && (phase8 < EDGE6)) ||
               (phase8 >= EDGE7);
        if (eight_bit_mode)
        begin
            level = high ? LEVEL_HIGH8 : LEVEL_LOW8;
        end
        else
        begin
            level = high ? LEVEL_HIGH16 : LEVEL_LOW16;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tape_fsk_byte_modulator.sv =====
// An accepted item's result is registered; it waits in the skid register on a stall.
// Throughput: one item per cycle; a two-deep output stage (result register plus
// skid register) keeps input and output apart, so input stalls only when both are full.
// Reset: clears the frame, bit count, tick position, checksum, eight-bit mode
// and both output stages; the block comes out of reset idle with no result pending.
`default_nettype none

module tape_fsk_byte_modulator
    import tfsk_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_write,
    input  wire logic cfg_data,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    logic       mode_reg;
    logic [9:0] frame_reg,  frame_next;
    logic [3:0] left_reg,   left_next;
    logic [7:0] index_reg,  index_next;
    logic [7:0] sum_reg,    sum_next;

    rsp_t res_next;
    rsp_t out_reg, skid_reg;
    logic out_valid_reg, skid_valid_reg;

    logic accept;
    logic take;
    logic busy;
    logic signed [15:0] level;

    tfsk_level u_level (
        .tick_index     (index_reg),
        .bit_value      (frame_reg[0]),
        .eight_bit_mode (mode_reg),
        .level          (level)
    );

    assign req_stall = skid_valid_reg;
    assign accept    = req_valid && !skid_valid_reg;
    assign take      = out_valid_reg && !rsp_stall;
    assign busy      = left_reg != 4'd0;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        frame_next = frame_reg;
        left_next  = left_reg;
        index_next = index_reg;
        sum_next   = sum_reg;
        res_next   = '0;
        case (req.cmd)
            CMD_TICK:
            begin
                if (busy)
                begin
                    res_next.sample       = level;
                    res_next.sample_valid = 1'b1;
                    if (index_reg == TICK_LAST)
                    begin
                        // advance to the next bit of the frame
                        index_next = 8'd0;
                        frame_next = {1'b0, frame_reg[9:1]};
                        left_next  = left_reg - 4'd1;
                    end
                    else
                    begin
                        index_next = index_reg + 8'd1;
                    end
                end
            end
            CMD_BYTE:
            begin
                if (!busy)
                begin
                    res_next.accepted = 1'b1;
                    frame_next = {1'b1, req.data_byte, 1'b0};
                    left_next  = FRAME_LEN;
                    index_next = 8'd0;
                    sum_next   = sum_reg + req.data_byte;
                end
            end
            CMD_LEADER:
            begin
                if (!busy)
                begin
                    res_next.accepted = 1'b1;
                    frame_next = 10'd1;
                    left_next  = 4'd1;
                    index_next = 8'd0;
                end
            end
            CMD_CHECKSUM:
            begin
                if (!busy)
                begin
                    // send the old sum, then fold it into itself
                    res_next.accepted = 1'b1;
                    frame_next = {1'b1, sum_reg, 1'b0};
                    left_next  = FRAME_LEN;
                    index_next = 8'd0;
                    sum_next   = {sum_reg[6:0], 1'b0};
                end
            end
            CMD_CLEAR:
            begin
                if (!busy)
                begin
                    res_next.accepted = 1'b1;
                    sum_next = 8'd0;
                end
            end
            default:
            begin
                res_next.accepted = 1'b0;
            end
        endcase
        res_next.busy_res = left_next != 4'd0;
        res_next.checksum = sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            frame_reg <= '0;
            left_reg  <= '0;
            index_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                mode_reg <= cfg_data;
            end
            if (accept)
            begin
                frame_reg <= frame_next;
                left_reg  <= left_next;
                index_reg <= index_next;
                sum_reg   <= sum_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (take)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (accept)
            begin
                if (!out_valid_reg || take)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || take)
            begin
                out_reg <= res_next;
            end
            else
            begin
                // hold the new item behind the stalled one
                skid_reg <= res_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tfsk_checker.sv =====
`default_nettype none

module tfsk_checker
    import tfsk_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic rsp_valid,
    input wire logic rsp_stall,
    input wire rsp_t rsp
);

    // a stalled result holds until taken
    property p_rsp_hold;
        @(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp);
    endproperty
    a_rsp_hold: assert property (p_rsp_hold)
        else $error("stalled result changed");

    // a tick never takes a command
    property p_tick_no_accept;
        @(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.sample_valid |-> !rsp.accepted;
    endproperty
    a_tick_no_accept: assert property (p_tick_no_accept)
        else $error("sample and command acceptance in one item");

    // no signal sample means a zero sample
    property p_idle_zero;
        @(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.sample_valid |-> rsp.sample == 16'sd0;
    endproperty
    a_idle_zero: assert property (p_idle_zero)
        else $error("non-zero sample without sample_valid");

    // a signal sample is one of the four levels
    property p_levels;
        @(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.sample_valid |->
            (rsp.sample == LEVEL_HIGH16) || (rsp.sample == LEVEL_LOW16) ||
            (rsp.sample == LEVEL_HIGH8)  || (rsp.sample == LEVEL_LOW8);
    endproperty
    a_levels: assert property (p_levels)
        else $error("sample level out of set");

endmodule

bind tape_fsk_byte_modulator tfsk_checker u_tfsk_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire

// ===== verif/tb.sv =====
module tb;
    import tfsk_pkg::*;

    localparam int CMD_SPACE    = 8;       // every code the 3-bit command field can carry
    localparam int PHASE_ITEMS  = 580;
    localparam int DRAIN_CYCLES = 8;
    localparam int SETTLE_WAIT  = 4;
    localparam int CYCLE_LIMIT  = 200000;

    class tape_signal_model;
        bit         eight_bit_mode;
        bit [9:0]   frame_bits;
        bit [3:0]   bits_left;
        bit [7:0]   tick_pos;
        bit [7:0]   running_sum;
        rsp_t       expected_samples[$];
        int         failures;

        function void set_mode(bit mode);
            eight_bit_mode = mode;
        endfunction

        function bit sending();
            return bits_left != 0;
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            failures++;
        endtask

        function void take_item(req_t item);
            rsp_t        r;
            int unsigned j;
            int unsigned k;
            r = '0;
            if (item.cmd == CMD_TICK) begin
                if (bits_left != 0) begin
                    j = tick_pos;
                    // a one bit runs its square wave at twice the rate
                    k = frame_bits[0] ? (2 * j) % BIT_TICKS : j;
                    if (((8 * k) / BIT_TICKS) % 2 == 1)
                        r.sample = eight_bit_mode ? LEVEL_HIGH8 : LEVEL_HIGH16;
                    else
                        r.sample = eight_bit_mode ? LEVEL_LOW8 : LEVEL_LOW16;
                    r.sample_valid = 1'b1;
                    if (j + 1 >= BIT_TICKS) begin
                        tick_pos   = '0;
                        frame_bits = frame_bits >> 1;
                        bits_left  = bits_left - 1'b1;
                    end
                    else
                        tick_pos = 8'(j + 1);
                end
            end
            else if (bits_left == 0 && item.cmd <= CMD_CLEAR) begin
                r.accepted = 1'b1;
                case (item.cmd)
                    CMD_BYTE: begin
                        frame_bits  = {1'b1, item.data_byte, 1'b0};
                        bits_left   = FRAME_LEN;
                        tick_pos    = '0;
                        running_sum = running_sum + item.data_byte;
                    end
                    CMD_LEADER: begin
                        frame_bits = 10'd1;
                        bits_left  = 4'd1;
                        tick_pos   = '0;
                    end
                    CMD_CHECKSUM: begin
                        // send the sum as it stood, then add it to itself
                        frame_bits  = {1'b1, running_sum, 1'b0};
                        bits_left   = FRAME_LEN;
                        tick_pos    = '0;
                        running_sum = running_sum << 1;
                    end
                    CMD_CLEAR:
                        running_sum = '0;
                    default: ;
                endcase
            end
            r.busy_res = bits_left != 0;
            r.checksum = running_sum;
            expected_samples.push_back(r);
        endfunction

        task check_result(rsp_t got);
            rsp_t want;
            if (expected_samples.size() == 0) begin
                report($sformatf("unexpected item %h", got));
                return;
            end
            want = expected_samples.pop_front();
            if (got.sample !== want.sample)
                report($sformatf("sample %0d, want %0d", got.sample, want.sample));
            if (got.sample_valid !== want.sample_valid)
                report($sformatf("sample_valid %b, want %b", got.sample_valid, want.sample_valid));
            if (got.accepted !== want.accepted)
                report($sformatf("accepted %b, want %b", got.accepted, want.accepted));
            if (got.busy_res !== want.busy_res)
                report($sformatf("busy_res %b, want %b", got.busy_res, want.busy_res));
            if (got.checksum !== want.checksum)
                report($sformatf("checksum %h, want %h", got.checksum, want.checksum));
        endtask
    endclass

    logic   clk       = 1'b0;
    logic   rst_n     = 1'b0;
    logic   cfg_write = 1'b0;
    logic   cfg_data  = 1'b0;
    logic   req_valid = 1'b0;
    logic   req_stall;
    req_t   req       = '0;
    logic   rsp_valid;
    logic   rsp_stall = 1'b0;
    rsp_t   rsp;

    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     cycle_count   = 0;

    tape_signal_model tape_signal = new();

    tape_fsk_byte_modulator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL tape_fsk_byte_modulator");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            tape_signal.check_result(rsp);
        rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Leave valid high on return so a back-to-back item needs no second drive.
    task automatic send_item(input logic [2:0] cmd, input logic [7:0] data_byte);
        req_t item;
        item.cmd       = cmd;
        item.data_byte = data_byte;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        tape_signal.take_item(item);
    endtask

    task automatic write_mode(input logic mode);
        req_valid <= 1'b0;
        while (tape_signal.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= mode;
        @(posedge clk);
        cfg_write <= 1'b0;
        tape_signal.set_mode(mode);
    endtask

    task automatic run_phase(input int n_items);
        int       pick;
        int       rare;
        logic [7:0] data_byte;
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            rare = $urandom_range(0, 9);
            data_byte = (rare == 0) ? 8'h00 : (rare == 1) ? 8'hFF : 8'($urandom);
            if (tape_signal.sending()) begin
                // mostly advance the frame; now and then a command that must bounce
                if (pick < 6)
                    send_item(3'($urandom_range(int'(CMD_BYTE), CMD_SPACE - 1)), data_byte);
                else
                    send_item(CMD_TICK, data_byte);
            end
            else if (pick < 10)
                send_item(CMD_TICK, data_byte);
            else if (pick < 14)
                send_item(3'($urandom_range(int'(CMD_CLEAR) + 1, CMD_SPACE - 1)), data_byte);
            else if (pick < 40)
                send_item(CMD_BYTE, data_byte);
            else if (pick < 70)
                send_item(CMD_LEADER, data_byte);
            else if (pick < 88)
                send_item(CMD_CHECKSUM, data_byte);
            else
                send_item(CMD_CLEAR, data_byte);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_mode(1'b0);
        // idle tick, unknown codes, a clear, then a leader bit with commands and ticks thrown at it
        send_item(CMD_TICK, 8'h00);
        send_item(3'(int'(CMD_CLEAR) + 1), 8'hFF);
        send_item(3'(int'(CMD_CLEAR) + 2), 8'h00);
        send_item(3'(CMD_SPACE - 1), 8'hFF);
        send_item(CMD_CLEAR, 8'h00);
        send_item(CMD_LEADER, 8'hFF);
        send_item(CMD_BYTE, 8'hFF);
        send_item(CMD_BYTE, 8'h00);
        send_item(CMD_LEADER, 8'h00);
        send_item(CMD_CHECKSUM, 8'h00);
        send_item(CMD_CLEAR, 8'hFF);
        repeat (4) send_item(CMD_TICK, 8'h00);

        write_mode(1'b1);
        send_idle_pct = 11;
        recv_idle_pct = 54;
        run_phase(PHASE_ITEMS);

        write_mode(1'b0);
        send_idle_pct = 54;
        recv_idle_pct = 11;
        run_phase(PHASE_ITEMS);

        write_mode(1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(PHASE_ITEMS);

        req_valid <= 1'b0;
        while (tape_signal.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tape_signal.pending() != 0)
            tape_signal.report("items still outstanding at the end");

        if (tape_signal.failures == 0)
            $display("PASS tape_fsk_byte_modulator");
        else
            $display("FAIL tape_fsk_byte_modulator");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tfsk_pkg.sv
rtl/tfsk_level.sv
rtl/tape_fsk_byte_modulator.sv
rtl/tfsk_checker.sv
verif/tb.sv
